// File: rtl/pftr_pkg.sv
// Shared types and constants for the packed pixel to RGBA single-float converter.
// No dependencies.
package pftr_pkg;

    localparam int NUM_LANES = 4;

    localparam logic [2:0] FMT_R16_HALF    = 3'd0;
    localparam logic [2:0] FMT_RGBA16_HALF = 3'd1;
    localparam logic [2:0] FMT_RGBA32_FLT  = 3'd2;
    localparam logic [2:0] FMT_RGBA8_UNORM = 3'd3;
    localparam logic [2:0] FMT_BGRA8_UNORM = 3'd4;

    localparam logic [2:0]  FMT_RESET = FMT_RGBA16_HALF;
    localparam logic [31:0] ONE_BITS  = 32'h3f80_0000;

    typedef struct packed {
        logic [63:0] pixel_low;
        logic [63:0] pixel_high;
    } t_pix_in;

    typedef struct packed {
        logic [31:0] red_bits;
        logic [31:0] green_bits;
        logic [31:0] blue_bits;
        logic [31:0] alpha_bits;
        logic        format_ok;
    } t_pix_out;

endpackage

// File: rtl/pftr_lane.sv
// One channel lane: widens a half to single and converts an 8-bit unorm to single.
// Depends on nothing outside this file.
module pftr_lane (
    input  logic [15:0] i_half,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_half_sp,
    output logic [31:0] o_unorm_sp
);

    logic        sgn;
    logic [4:0]  hex;
    logic [9:0]  man;
    logic [3:0]  q;
    logic [10:0] nsh;
    logic [2:0]  p;
    logic [39:0] rep;
    logic [39:0] rsh;
    logic [22:0] umant;

    always_comb begin
        sgn = i_half[15];
        hex = i_half[14:10];
        man = i_half[9:0];
        q   = '0;
        for (int k = 0; k < 10; k++) begin
            if (man[k]) q = 4'(k);
        end
        nsh = {1'b0, man} << (4'd10 - q);
        if (hex == 5'd0) begin
            if (man == 10'd0) begin
                o_half_sp = {sgn, 31'd0};
            end else begin
                o_half_sp = {sgn, 8'd103 + {4'd0, q}, nsh[9:0], 13'd0};
            end
        end else if (hex == 5'h1f) begin
            o_half_sp = {sgn, 8'hff, man, 13'd0};
        end else begin
            o_half_sp = {sgn, {3'd0, hex} + 8'd112, man, 13'd0};
        end
    end

    // The quotient byte/255 is the byte repeated forever after the binary point.
    always_comb begin
        p = '0;
        for (int k = 0; k < 8; k++) begin
            if (i_byte[k]) p = 3'(k);
        end
        rep   = {5{i_byte}};
        rsh   = rep >> (6'd8 + {3'd0, p});
        umant = rsh[23:1] + {22'd0, rsh[0]};
        if (i_byte == 8'd0) begin
            o_unorm_sp = 32'd0;
        end else if (i_byte == 8'hff) begin
            o_unorm_sp = 32'h3f80_0000;
        end else begin
            o_unorm_sp = {1'b0, 8'd119 + {5'd0, p}, umant};
        end
    end

endmodule

// File: rtl/pixel_format_to_rgba_float.sv
// Top level: format register, four conversion lanes, channel merge and output register.
// Depends on pftr_pkg and pftr_lane.
//
//   channel  valid        ready        payload
//   input    i_in_valid   o_in_ready   i_pixel
//   output   o_out_valid  i_out_ready  o_result
//   config   i_cfg_valid  o_cfg_ready  i_cfg_data
//
// One pixel per cycle while the output is not stalled; a result appears in the cycle after its input transfer.
// The single output register sets the latency; lanes are combinational.
// Synchronous active-low reset clears the valid flag and sets the format to RGBA16 half.
// A stalled output holds its result; the input is taken again as soon as it drains.
module pixel_format_to_rgba_float (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pftr_pkg::t_pix_in i_pixel,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pftr_pkg::t_pix_out o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_data
);
    import pftr_pkg::*;

    logic [2:0]  r_pixel_format;
    logic        r_out_valid;
    logic        n_out_valid;
    t_pix_out    r_result;
    t_pix_out    n_result;
    logic [7:0]  lane_byte [NUM_LANES];
    logic [31:0] half_sp   [NUM_LANES];
    logic [31:0] unorm_sp  [NUM_LANES];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_byte[i] = i_pixel.pixel_low[8*i +: 8];
        end
        if (r_pixel_format == FMT_BGRA8_UNORM) begin
            lane_byte[0] = i_pixel.pixel_low[23:16];
            lane_byte[2] = i_pixel.pixel_low[7:0];
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        pftr_lane u_lane (
            .i_half     (i_pixel.pixel_low[16*g +: 16]),
            .i_byte     (lane_byte[g]),
            .o_half_sp  (half_sp[g]),
            .o_unorm_sp (unorm_sp[g])
        );
    end

    always_comb begin
        n_result = '0;
        n_result.format_ok = 1'b1;
        unique case (r_pixel_format) inside
            FMT_R16_HALF: begin
                n_result.red_bits   = half_sp[0];
                n_result.alpha_bits = ONE_BITS;
            end
            FMT_RGBA16_HALF: begin
                n_result.red_bits   = half_sp[0];
                n_result.green_bits = half_sp[1];
                n_result.blue_bits  = half_sp[2];
                n_result.alpha_bits = half_sp[3];
            end
            FMT_RGBA32_FLT: begin
                n_result.red_bits   = i_pixel.pixel_low[31:0];
                n_result.green_bits = i_pixel.pixel_low[63:32];
                n_result.blue_bits  = i_pixel.pixel_high[31:0];
                n_result.alpha_bits = i_pixel.pixel_high[63:32];
            end
            FMT_RGBA8_UNORM, FMT_BGRA8_UNORM: begin
                n_result.red_bits   = unorm_sp[0];
                n_result.green_bits = unorm_sp[1];
                n_result.blue_bits  = unorm_sp[2];
                n_result.alpha_bits = unorm_sp[3];
            end
            default: begin
                n_result.format_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_in_ready) begin
            n_out_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_pixel_format <= FMT_RESET;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_pixel_format <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_result <= n_result;
        end
    end

endmodule

// File: rtl/pftr_checker.sv
// Port-level checks for pixel_format_to_rgba_float and the bind that attaches them.
// Depends on pftr_pkg and the top level's ports.
module pftr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pftr_pkg::t_pix_out o_result
);
    import pftr_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_result)))
        else $error("Stalled result changed.");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("Input transfer produced no result.");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input not ready while output is empty.");

    a_bad_fmt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_result.format_ok) |->
        (o_result.red_bits == 32'd0 && o_result.green_bits == 32'd0 &&
         o_result.blue_bits == 32'd0 && o_result.alpha_bits == 32'd0))
        else $error("Unsupported format returned nonzero channels.");

endmodule

bind pixel_format_to_rgba_float pftr_checker u_pftr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_result    (o_result)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for pixel_format_to_rgba_float: random and directed pixels in every format.
// Depends on pftr_pkg and the converter RTL.
module testbench;
    import pftr_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_pix_in    i_pixel = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_pix_out   o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_data = '0;

    logic [2:0] cur_fmt = FMT_RESET;
    t_pix_out   expected_pixels[$];
    int         in_idle_pct = 0;
    int         out_idle_pct = 0;
    int         hold_cycles = 0;
    int         errors = 0;
    int         pixels_sent = 0;
    int         pixels_checked = 0;

    pixel_format_to_rgba_float DUT (.*);

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [10:0] m;
        int          sh;
        m = {1'b0, h[9:0]};
        sh = 0;
        if (h[14:10] == 5'd0) begin
            if (h[9:0] == 10'd0) return {h[15], 31'd0};
            while (!m[10]) begin
                m = m << 1;
                sh++;
            end
            return {h[15], 8'(113 - sh), m[9:0], 13'd0};
        end
        if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
        return {h[15], 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
    endfunction

    // The quotient byte/255 is never a tie, so round to nearest needs only the remainder.
    function automatic logic [31:0] byte_to_unit(input logic [7:0] b);
        longint unsigned num;
        longint unsigned mant;
        longint unsigned rem;
        int              k;
        if (b == 8'd0) return 32'd0;
        if (b == 8'hff) return ONE_BITS;
        k = 0;
        while ((longint'(b) << k) < 255) k++;
        num = longint'(b) << (k + 23);
        mant = num / 255;
        rem = num % 255;
        if (2 * rem > 255) mant++;
        return {1'b0, 8'(127 - k), mant[22:0]};
    endfunction

    function automatic t_pix_out convert_pixel(input logic [2:0] fmt, input t_pix_in p);
        t_pix_out   r;
        logic [7:0] b0;
        logic [7:0] b2;
        r = '0;
        r.format_ok = 1'b1;
        b0 = p.pixel_low[7:0];
        b2 = p.pixel_low[23:16];
        case (fmt) inside
            FMT_R16_HALF: begin
                r.red_bits = half_to_single(p.pixel_low[15:0]);
                r.alpha_bits = ONE_BITS;
            end
            FMT_RGBA16_HALF: begin
                r.red_bits = half_to_single(p.pixel_low[15:0]);
                r.green_bits = half_to_single(p.pixel_low[31:16]);
                r.blue_bits = half_to_single(p.pixel_low[47:32]);
                r.alpha_bits = half_to_single(p.pixel_low[63:48]);
            end
            FMT_RGBA32_FLT: begin
                r.red_bits = p.pixel_low[31:0];
                r.green_bits = p.pixel_low[63:32];
                r.blue_bits = p.pixel_high[31:0];
                r.alpha_bits = p.pixel_high[63:32];
            end
            FMT_RGBA8_UNORM, FMT_BGRA8_UNORM: begin
                if (fmt == FMT_BGRA8_UNORM) begin
                    b0 = p.pixel_low[23:16];
                    b2 = p.pixel_low[7:0];
                end
                r.red_bits = byte_to_unit(b0);
                r.green_bits = byte_to_unit(p.pixel_low[15:8]);
                r.blue_bits = byte_to_unit(b2);
                r.alpha_bits = byte_to_unit(p.pixel_low[31:24]);
            end
            default: r.format_ok = 1'b0;
        endcase
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_pixels.push_back(convert_pixel(cur_fmt, i_pixel));
            pixels_sent++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (want.red_bits !== o_result.red_bits)
                    $display("%0t: red expected %h actual %h", $time,
                             want.red_bits, o_result.red_bits);
                if (want.green_bits !== o_result.green_bits)
                    $display("%0t: green expected %h actual %h", $time,
                             want.green_bits, o_result.green_bits);
                if (want.blue_bits !== o_result.blue_bits)
                    $display("%0t: blue expected %h actual %h", $time,
                             want.blue_bits, o_result.blue_bits);
                if (want.alpha_bits !== o_result.alpha_bits)
                    $display("%0t: alpha expected %h actual %h", $time,
                             want.alpha_bits, o_result.alpha_bits);
                if (want.format_ok !== o_result.format_ok)
                    $display("%0t: format_ok expected %b actual %b", $time,
                             want.format_ok, o_result.format_ok);
                if (want !== o_result) errors++;
            end
        end
    end

    task automatic send_pixel(input logic [63:0] lo, input logic [63:0] hi);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pixel = '{pixel_low: lo, pixel_high: hi};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (expected_pixels.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_format(input logic [2:0] fmt);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = fmt;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_fmt = fmt;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_half();
        logic [15:0] h;
        h = 16'($urandom);
        case ($urandom_range(5))
            0: h[14:10] = 5'd0;
            1: h[14:10] = 5'h1f;
            2: h[9:0] = 10'd0;
            default: ;
        endcase
        return h;
    endfunction

    function automatic logic [63:0] pick_low(input logic [2:0] fmt);
        if (fmt <= FMT_RGBA16_HALF)
            return {pick_half(), pick_half(), pick_half(), pick_half()};
        return {$urandom, $urandom};
    endfunction

    task automatic test_reset_format;
        send_pixel(64'h7c00_fc00_8000_0001, 64'hffff_ffff_ffff_ffff);
        send_pixel(64'h7e01_03ff_3c00_7bff, 64'd0);
        drain();
    endtask

    task automatic test_directed;
        write_format(FMT_R16_HALF);
        send_pixel(64'hffff_ffff_ffff_0000, 64'hffff_ffff_ffff_ffff);
        send_pixel(64'd0, 64'd0);
        send_pixel(64'h0000_0000_0000_ffff, 64'd0);
        send_pixel(64'h1234_5678_9abc_0200, 64'd0);
        drain();
        write_format(FMT_RGBA32_FLT);
        send_pixel(64'hffff_ffff_7f80_0001, 64'h0000_0000_ffff_ffff);
        send_pixel(64'd0, 64'hffff_ffff_ffff_ffff);
        drain();
        write_format(FMT_RGBA8_UNORM);
        send_pixel(64'hffff_ffff_00ff_8001, 64'd0);
        send_pixel(64'h0000_0000_ff00_7f02, 64'hffff_ffff_ffff_ffff);
        drain();
        write_format(FMT_BGRA8_UNORM);
        send_pixel(64'h0000_0000_ff00_7f02, 64'd0);
        send_pixel(64'hffff_ffff_01ff_80fe, 64'd0);
        drain();
        write_format(3'd5);
        send_pixel(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        drain();
        write_format(3'd7);
        send_pixel(64'h3c00_3c00_3c00_3c00, 64'd1);
        drain();
    endtask

    task automatic test_random(input int count);
        logic [2:0] fmt;
        repeat (8) begin
            fmt = 3'($urandom_range(7));
            if ($urandom_range(9) < 7) fmt = 3'($urandom_range(4));
            write_format(fmt);
            repeat (count / 8) send_pixel(pick_low(fmt), {$urandom, $urandom});
            drain();
        end
    endtask

    task automatic test_backpressure;
        int saved;
        saved = in_idle_pct;
        in_idle_pct = 0;
        write_format(FMT_RGBA16_HALF);
        hold_cycles = 200;
        repeat (40) send_pixel(pick_low(FMT_RGBA16_HALF), 64'd0);
        drain();
        in_idle_pct = saved;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_format();
        test_directed();
        in_idle_pct = 27;
        out_idle_pct = 84;
        test_random(480);
        test_backpressure();
        in_idle_pct = 84;
        out_idle_pct = 27;
        test_random(480);
        in_idle_pct = 0;
        out_idle_pct = 0;
        test_random(560);
        $display("Covered %0d pixels over every supported format and unsupported codes, %0d %s",
                 pixels_sent, pixels_checked, "results checked.");
        $display("Idle mixes and a long output stall included; %0d errors.", errors);
        if (errors == 0)
            $display("PASS pixel_format_to_rgba_float");
        else
            $display("FAIL pixel_format_to_rgba_float");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAIL pixel_format_to_rgba_float");
        $finish;
    end
endmodule

// File: filelist.f
rtl/pftr_pkg.sv
rtl/pftr_lane.sv
rtl/pixel_format_to_rgba_float.sv
rtl/pftr_checker.sv
bench/testbench.sv
